[design/kvmp_pkg.sv]
package kvmp_pkg;

    localparam int KEY_COUNT              = 7;
    localparam int MAX_EVENTS             = 3;
    localparam int FIFO_DEPTH             = 4;
    localparam int PATH_CAPACITY_DEFAULT  = 64;
    localparam int MODE_CAPACITY_DEFAULT  = 32;
    localparam int KEY_TEXT_W             = 19;

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_HASH = 8'h23;

    localparam logic [KEY_COUNT-1:0] ALL_KEYS = '1;

    // key ids whose values use the short capacity
    localparam logic [2:0] KEY_MODE    = 3'd3;
    localparam logic [2:0] KEY_RESTART = 3'd6;

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_KEY     = 4'b0010,
        PH_VALUE   = 4'b0100,
        PH_COMMENT = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        EV_VALUE    = 2'd0,
        EV_COMPLETE = 2'd1,
        EV_STATUS   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  key_id;
        logic [5:0]  position;
        logic [7:0]  value_byte;
        t_status     status;
    } t_event;

    typedef struct packed {
        logic [1:0]                   count;
        t_event [MAX_EVENTS-1:0]      ev;
    } t_push;

    typedef struct packed {
        logic                 done;
        logic [2:0]           done_id;
        logic [KEY_COUNT-1:0] keep;
    } t_key_match;

    function automatic logic [4:0] key_len(input logic [2:0] k);
        logic [4:0] len;
        begin
            unique case (k)
                3'd0:    len = 5'd8;
                3'd1:    len = 5'd16;
                3'd2:    len = 5'd19;
                3'd3:    len = 5'd5;
                3'd4:    len = 5'd14;
                3'd5:    len = 5'd13;
                3'd6:    len = 5'd14;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Character of key k at offset off; zero past the end of the key.
    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [4:0] off);
        logic [8*KEY_TEXT_W-1:0] text;
        logic [4:0]              len;
        int                      pos;
        begin
            len = key_len(k);
            unique case (k)
                3'd0:    text = (8*KEY_TEXT_W)'("service=");
                3'd1:    text = (8*KEY_TEXT_W)'({"service_", "manager="});
                3'd2:    text = (8*KEY_TEXT_W)'({"service_", "descriptor="});
                3'd3:    text = (8*KEY_TEXT_W)'("mode=");
                3'd4:    text = (8*KEY_TEXT_W)'({"child_", "service="});
                3'd5:    text = (8*KEY_TEXT_W)'({"child_", "parent="});
                3'd6:    text = (8*KEY_TEXT_W)'({"child_", "restart="});
                default: text = '0;
            endcase
            if (off < len) begin
                pos = 8 * (int'(len) - 1 - int'(off));
                return text[pos +: 8];
            end
            return 8'h00;
        end
    endfunction

endpackage

[design/key_value_manifest_parser.sv]
// Manifest parser: takes one manifest byte per transfer on the slave side
// (tlast on the final byte) and delivers value bytes, value completions and
// one final status per manifest on the master side. A byte is taken in the
// cycle it is offered whenever the four-entry result queue has room for
// three results, and its results are visible from the following cycle.
// While the master side is ready, one transfer leaves per cycle and, as
// most bytes give at most one result, one byte is taken per cycle; a byte
// that gives k results (at most three: a value byte, a completion and the
// status on the final byte) needs k output transfers. Comment lines and
// key bytes give no results. tuser carries the event kind (0 value byte,
// 1 completion, 2 status). After any bad line all later bytes of the same
// manifest are dropped until the final byte, which reports status 1.
module key_value_manifest_parser
    import kvmp_pkg::*;
#(
    parameter int PATH_CAPACITY = PATH_CAPACITY_DEFAULT,
    parameter int MODE_CAPACITY = MODE_CAPACITY_DEFAULT
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [2:0] key_id, [8:3] position,
                                          // [16:9] value_byte, [18:17] status
    output logic [1:0]  o_m_axis_tuser    // [1:0] event_kind
);

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    logic             w_s_accept;
    t_push            w_push;
    t_event           w_head;
    logic             w_room;
    logic [LVL_W-1:0] w_level;

    assign w_s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = w_room;

    // Per-byte line state and event generation.
    kvmp_line_fsm #(
        .PATH_CAPACITY (PATH_CAPACITY),
        .MODE_CAPACITY (MODE_CAPACITY)
    ) u_line_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_s_accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (w_push)
    );

    // Result queue: parts the two sides and absorbs bursts of three.
    kvmp_event_fifo u_event_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_m_axis_tready),
        .o_head  (w_head),
        .o_valid (o_m_axis_tvalid),
        .o_room  (w_room),
        .o_level (w_level)
    );

    assign o_m_axis_tuser = w_head.kind;
    assign o_m_axis_tdata = {5'd0, w_head.status, w_head.value_byte,
                             w_head.position, w_head.key_id};

    // queue never overfills
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= LVL_W'(FIFO_DEPTH))
        else $error("result queue over its depth");

    // every final byte yields at least the status transfer
    a_last_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && i_s_axis_tlast) |-> (w_push.count != 2'd0))
        else $error("final byte without status");

    // status only on the final byte
    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && !i_s_axis_tlast) |->
            ((w_push.ev[0].kind != EV_STATUS) && (w_push.ev[1].kind != EV_STATUS) &&
             (w_push.ev[2].kind != EV_STATUS)))
        else $error("status before final byte");

    // a stalled output is never lost from the queue
    a_hold_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (w_level != '0))
        else $error("stalled result dropped");

endmodule

[design/kvmp_key_match.sv]
module kvmp_key_match
    import kvmp_pkg::*;
(
    input  logic [7:0]           i_byte,
    input  logic [KEY_COUNT-1:0] i_cand,
    input  logic [4:0]           i_off,
    output t_key_match           o_match
);

    // Compare the byte against every surviving key; the highest finishing key wins.
    always_comb begin
        o_match = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (i_cand[k] && (i_off < key_len(3'(k))) && (key_char(3'(k), i_off) == i_byte)) begin
                if ((i_off + 5'd1) == key_len(3'(k))) begin
                    o_match.done    = 1'b1;
                    o_match.done_id = 3'(k);
                end else begin
                    o_match.keep[k] = 1'b1;
                end
            end
        end
    end

endmodule

[design/kvmp_line_fsm.sv]
module kvmp_line_fsm
    import kvmp_pkg::*;
#(
    parameter int PATH_CAPACITY = PATH_CAPACITY_DEFAULT,
    parameter int MODE_CAPACITY = MODE_CAPACITY_DEFAULT
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_push      o_push
);

    localparam int LW = $clog2((PATH_CAPACITY > MODE_CAPACITY) ? PATH_CAPACITY : MODE_CAPACITY);
    localparam logic [LW:0] PATH_LIM = (LW+1)'(PATH_CAPACITY);
    localparam logic [LW:0] MODE_LIM = (LW+1)'(MODE_CAPACITY);

    t_phase               r_phase, n_phase;
    logic [KEY_COUNT-1:0] r_cand, n_cand;
    logic [4:0]           r_off, n_off;
    logic [2:0]           r_key, n_key;
    logic [LW-1:0]        r_len, n_len;
    logic [KEY_COUNT-1:0] r_seen, n_seen;
    logic                 r_held, n_held;
    logic                 r_err, n_err;

    t_key_match           w_match;
    logic [KEY_COUNT-1:0] w_cand;
    logic [4:0]           w_off;
    t_event [MAX_EVENTS-1:0] w_ev;
    logic [1:0]           w_n;

    // A line that starts here matches from the first key character.
    assign w_cand = (r_phase == PH_START) ? ALL_KEYS : r_cand;
    assign w_off  = (r_phase == PH_START) ? 5'd0 : r_off;

    kvmp_key_match u_key_match (
        .i_byte  (i_byte),
        .i_cand  (w_cand),
        .i_off   (w_off),
        .o_match (w_match)
    );

    always_comb begin
        logic          end_req;
        logic [LW:0]   lim;
        n_phase = r_phase;
        n_cand  = r_cand;
        n_off   = r_off;
        n_key   = r_key;
        n_len   = r_len;
        n_seen  = r_seen;
        n_held  = r_held;
        n_err   = r_err;
        w_ev    = '0;
        w_n     = 2'd0;
        end_req = 1'b0;
        lim     = ((r_key == KEY_MODE) || (r_key == KEY_RESTART)) ? MODE_LIM : PATH_LIM;

        // line byte
        if (!r_err) begin
            if (r_held) begin
                n_held = 1'b0;
                if (i_byte == CH_LF) begin
                    end_req = 1'b1;
                end else begin
                    n_err = 1'b1;
                end
            end else if (i_byte == CH_LF) begin
                if ((r_phase == PH_START) || (r_phase == PH_COMMENT)) begin
                    n_phase = PH_START;
                    n_cand  = ALL_KEYS;
                    n_off   = 5'd0;
                end else begin
                    end_req = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_START, PH_KEY: begin
                        if (i_byte == CH_CR) begin
                            if (r_phase == PH_START) begin
                                n_held = 1'b1;
                            end else begin
                                n_err = 1'b1;
                            end
                        end else if ((r_phase == PH_START) && (i_byte == CH_HASH)) begin
                            n_phase = PH_COMMENT;
                        end else if (w_match.done) begin
                            n_phase = PH_VALUE;
                            n_key   = w_match.done_id;
                            n_len   = '0;
                        end else if (w_match.keep == '0) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase = PH_KEY;
                            n_cand  = w_match.keep;
                            n_off   = w_off + 5'd1;
                        end
                    end
                    PH_VALUE: begin
                        if (i_byte == CH_CR) begin
                            n_held = 1'b1;
                        end else if ((i_byte == CH_NUL) || (({1'b0, r_len} + 1'b1) >= lim)) begin
                            n_err = 1'b1;
                        end else begin
                            w_ev[w_n] = '{kind: EV_VALUE, key_id: r_key, position: 6'(r_len),
                                          value_byte: i_byte, status: ST_OK};
                            w_n   = w_n + 2'd1;
                            n_len = r_len + 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (end_req) begin
            if (n_phase == PH_KEY) begin
                n_err = 1'b1;
            end else if (n_phase == PH_VALUE) begin
                if (n_len == '0) begin
                    n_err = 1'b1;
                end else begin
                    w_ev[w_n] = '{kind: EV_COMPLETE, key_id: n_key, position: 6'(n_len),
                                  value_byte: 8'h00, status: ST_OK};
                    w_n           = w_n + 2'd1;
                    n_seen[n_key] = 1'b1;
                end
            end
            n_phase = PH_START;
            n_cand  = ALL_KEYS;
            n_off   = 5'd0;
            n_held  = 1'b0;
        end

        // end of manifest closes the open line, reports and starts afresh
        if (i_last) begin
            if (!n_err) begin
                if (n_phase == PH_KEY) begin
                    n_err = 1'b1;
                end else if (n_phase == PH_VALUE) begin
                    if (n_len == '0) begin
                        n_err = 1'b1;
                    end else begin
                        w_ev[w_n] = '{kind: EV_COMPLETE, key_id: n_key, position: 6'(n_len),
                                      value_byte: 8'h00, status: ST_OK};
                        w_n           = w_n + 2'd1;
                        n_seen[n_key] = 1'b1;
                    end
                end
            end
            w_ev[w_n] = '{kind: EV_STATUS, key_id: 3'd0, position: 6'd0, value_byte: 8'h00,
                          status: n_err ? ST_BAD :
                                  ((n_seen != ALL_KEYS) ? ST_MISSING : ST_OK)};
            w_n     = w_n + 2'd1;
            n_phase = PH_START;
            n_cand  = ALL_KEYS;
            n_off   = 5'd0;
            n_key   = 3'd0;
            n_len   = '0;
            n_seen  = '0;
            n_held  = 1'b0;
            n_err   = 1'b0;
        end
    end

    assign o_push.count = i_accept ? w_n : 2'd0;
    assign o_push.ev    = w_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_cand  <= ALL_KEYS;
            r_off   <= 5'd0;
            r_key   <= 3'd0;
            r_len   <= '0;
            r_seen  <= '0;
            r_held  <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cand  <= n_cand;
            r_off   <= n_off;
            r_key   <= n_key;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_held  <= n_held;
            r_err   <= n_err;
        end
    end

endmodule

[design/kvmp_event_fifo.sv]
module kvmp_event_fifo
    import kvmp_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_push                               i_push,
    input  logic                                i_pop,
    output t_event                              o_head,
    output logic                                o_valid,
    output logic                                o_room,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]     o_level
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    t_event             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [LVL_W-1:0]   r_count, n_count;
    logic               w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign n_count = r_count + LVL_W'(i_push.count) - LVL_W'(w_pop);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_EVENTS; i++) begin
            if (i < int'(i_push.count)) begin
                r_mem[r_wr + PTR_W'(i)] <= i_push.ev[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.count);
            r_rd    <= r_rd + PTR_W'(w_pop);
            r_count <= n_count;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    // room for the largest burst one byte can cause
    assign o_room  = (r_count <= LVL_W'(FIFO_DEPTH - MAX_EVENTS));
    assign o_level = r_count;

endmodule
